/* hw/rtl/tlc_pkg.sv */
// Shared types and constants of the traffic light controller core.
// Used by tlc_step and by the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tlc_pkg;

    localparam int DUR_W   = 7;
    localparam int IN_W    = 8;
    localparam int OUT_W   = 24;

    // Bit positions in the latched tick flags.
    localparam int TK_SEC   = 0;
    localparam int TK_BLINK = 1;
    localparam int TK_SEG   = 2;

    // Colour index into the duration tables and into a road's lamp group.
    localparam logic [1:0] COL_RED    = 2'd0;
    localparam logic [1:0] COL_YELLOW = 2'd1;
    localparam logic [1:0] COL_GREEN  = 2'd2;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_RED    = 2'd1,
        MODE_YELLOW = 2'd2,
        MODE_GREEN  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_RED    = 2'd0,
        PH_GREEN  = 2'd1,
        PH_YELLOW = 2'd2
    } phase_t;

    typedef struct packed {
        logic sec_tick;
        logic blink_tick;
        logic seg_tick;
        logic btn_mode;
        logic btn_up;
        logic btn_down;
        logic btn_commit;
    } item_t;

    typedef struct packed {
        mode_t                       mode;
        phase_t                      main_phase;
        phase_t                      side_phase;
        logic [DUR_W-1:0]            main_rem;
        logic [DUR_W-1:0]            side_rem;
        logic [2:0][DUR_W-1:0]       active;
        logic [2:0][DUR_W-1:0]       pending;
        logic [5:0]                  lamps;     // main red/yellow/green, then side
        logic [1:0][DUR_W-1:0]       shown;     // [0] left, [1] right
        logic [2:0]                  tick;
    } state_t;

    typedef struct packed {
        logic [5:0]       lamps;
        logic [DUR_W-1:0] display_left;
        logic [DUR_W-1:0] display_right;
        mode_t            current_mode;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/tlc_step.sv */
// Next-state and result logic for one scan of the controller.
// Purely combinational; uses the types of tlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlc_step #(
    parameter int MAX_DURATION = 99
) (
    input  tlc_pkg::state_t  st_i,
    input  tlc_pkg::item_t   item_i,
    output tlc_pkg::state_t  st_o,
    output tlc_pkg::result_t res_o
);

    localparam logic [tlc_pkg::DUR_W-1:0] MAX_D = tlc_pkg::DUR_W'(MAX_DURATION);

    typedef struct packed {
        tlc_pkg::phase_t             phase;
        logic [tlc_pkg::DUR_W-1:0]   rem;
        logic [2:0]                  lamps;
    } road_t;

    // One second of one road: lamps follow the phase before the change.
    function automatic road_t road_second(
        input tlc_pkg::phase_t                 phase,
        input logic [tlc_pkg::DUR_W-1:0]       rem,
        input logic [2:0]                      lamps,
        input logic [2:0][tlc_pkg::DUR_W-1:0]  active
    );
        road_t r;
        r.phase = phase;
        r.rem   = rem;
        r.lamps = lamps;
        unique case (phase)
            tlc_pkg::PH_RED: begin
                r.lamps = 3'b001;
                if (rem == '0) begin
                    r.phase = tlc_pkg::PH_GREEN;
                    r.rem   = active[tlc_pkg::COL_GREEN];
                end
            end
            tlc_pkg::PH_YELLOW: begin
                r.lamps = 3'b010;
                if (rem == '0) begin
                    r.phase = tlc_pkg::PH_RED;
                    r.rem   = active[tlc_pkg::COL_RED];
                end
            end
            tlc_pkg::PH_GREEN: begin
                r.lamps = 3'b100;
                if (rem == '0) begin
                    r.phase = tlc_pkg::PH_YELLOW;
                    r.rem   = active[tlc_pkg::COL_YELLOW];
                end
            end
            default: begin
                // An unreachable phase code keeps lamps and phase.
            end
        endcase
        r.rem = r.rem - tlc_pkg::DUR_W'(1);
        return r;
    endfunction

    always_comb begin
        road_t            rm;
        road_t            rs;
        logic [2:0]       tp;
        logic [1:0]       k;
        logic [1:0]       kn;
        logic [5:0]       both;
        tlc_pkg::mode_t   m;

        st_o = st_i;
        tp   = st_i.tick | {item_i.seg_tick, item_i.blink_tick, item_i.sec_tick};
        k    = 2'(st_i.mode) - 2'd1;
        both = 6'b001001 << k;
        rm   = road_second(st_i.main_phase, st_i.main_rem, st_i.lamps[2:0], st_i.active);
        rs   = road_second(st_i.side_phase, st_i.side_rem, st_i.lamps[5:3], st_i.active);

        if (st_i.mode == tlc_pkg::MODE_NORMAL) begin
            if (tp[tlc_pkg::TK_SEC]) begin
                st_o.shown[0]   = st_i.main_rem;
                st_o.shown[1]   = st_i.side_rem;
                st_o.main_phase = rm.phase;
                st_o.main_rem   = rm.rem;
                st_o.side_phase = rs.phase;
                st_o.side_rem   = rs.rem;
                st_o.lamps      = {rs.lamps, rm.lamps};
                tp[tlc_pkg::TK_SEC] = 1'b0;
            end
        end else begin
            // Adjust modes blink only the selected colour on both roads.
            st_o.lamps = st_i.lamps & both;
            if (tp[tlc_pkg::TK_BLINK]) begin
                st_o.lamps = st_o.lamps ^ both;
                tp[tlc_pkg::TK_BLINK] = 1'b0;
            end
        end

        m = st_i.mode;
        if (item_i.btn_mode) begin
            m = tlc_pkg::mode_t'(2'(st_i.mode) + 2'd1);
            if (m == tlc_pkg::MODE_NORMAL) begin
                st_o.main_phase = tlc_pkg::PH_RED;
                st_o.side_phase = tlc_pkg::PH_GREEN;
                st_o.main_rem   = st_i.active[tlc_pkg::COL_RED];
                st_o.side_rem   = st_i.active[tlc_pkg::COL_GREEN];
            end
        end else if (st_i.mode != tlc_pkg::MODE_NORMAL) begin
            priority if (item_i.btn_up) begin
                if (st_i.pending[k] < MAX_D) begin
                    st_o.pending[k] = st_i.pending[k] + tlc_pkg::DUR_W'(1);
                end else begin
                    st_o.pending[k] = MAX_D;
                end
            end else if (item_i.btn_down) begin
                if (st_i.pending[k] > tlc_pkg::DUR_W'(1)) begin
                    st_o.pending[k] = st_i.pending[k] - tlc_pkg::DUR_W'(1);
                end else begin
                    st_o.pending[k] = tlc_pkg::DUR_W'(1);
                end
            end else if (item_i.btn_commit) begin
                st_o.active[k] = st_i.pending[k];
            end
        end
        st_o.mode = m;

        kn = 2'(m) - 2'd1;
        if (tp[tlc_pkg::TK_SEG]) begin
            if (m != tlc_pkg::MODE_NORMAL) begin
                st_o.shown[0] = st_o.pending[kn];
                st_o.shown[1] = {5'd0, 2'(m)} + tlc_pkg::DUR_W'(1);
            end
            tp[tlc_pkg::TK_SEG] = 1'b0;
        end
        st_o.tick = tp;
    end

    always_comb begin
        res_o.lamps         = st_o.lamps;
        res_o.display_left  = st_o.shown[0];
        res_o.display_right = st_o.shown[1];
        res_o.current_mode  = st_o.mode;
    end

endmodule

`default_nettype wire

/* hw/rtl/traffic_light_controller_core.sv */
// Top level of the traffic light controller: input register, scan logic, result register.
// Depends on tlc_pkg and tlc_step.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// Each input beat on the s_ channel is one scan: tick flags and button presses.
// Each scan yields exactly one result beat on the m_ channel with the six lamp
// states, both display values and the mode after the scan.
// An accepted beat sits in the input register, is worked by the scan logic and
// lands in the result register, from which its result is given on the m_
// channel. One beat is taken and one result given in every cycle while the
// receiver does not stall; the scan logic is a single pass of compares,
// increments and muxes on the controller state, which closes the loop from one
// scan to the next.
// If the receiver stalls, the result register holds its beat; a beat held in
// the input register waits there, and s_tready is low until m_tready returns.
// Reset (aresetn low, synchronous) empties both registers and puts the
// controller in normal mode: main road red, side road green, both counts 1,
// all durations 1, lamps off, displays 0, no tick pending.
module traffic_light_controller_core #(
    parameter int MAX_DURATION = 99
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // sec_tick, blink_tick, seg_tick, btn_mode, btn_up, btn_down, btn_commit, pad
    input  wire logic [tlc_pkg::IN_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // main_red, main_yellow, main_green, side_red, side_yellow, side_green,
    // display_left[6:0], display_right[6:0], current_mode[1:0], pad[1:0]
    output logic [tlc_pkg::OUT_W-1:0]      m_tdata
);

    localparam tlc_pkg::state_t RESET_STATE = '{
        mode:       tlc_pkg::MODE_NORMAL,
        main_phase: tlc_pkg::PH_RED,
        side_phase: tlc_pkg::PH_GREEN,
        main_rem:   tlc_pkg::DUR_W'(1),
        side_rem:   tlc_pkg::DUR_W'(1),
        active:     {3{tlc_pkg::DUR_W'(1)}},
        pending:    {3{tlc_pkg::DUR_W'(1)}},
        lamps:      6'd0,
        shown:      '0,
        tick:       3'd0
    };

    logic                       in_valid_reg, in_valid_next;
    tlc_pkg::item_t             in_item_reg, in_item_next;
    tlc_pkg::state_t            st_reg, st_next, st_step;
    logic                       out_valid_reg, out_valid_next;
    logic [tlc_pkg::OUT_W-1:0]  out_data_reg, out_data_next;
    tlc_pkg::result_t           res_step;
    logic                       s_accept;
    logic                       process;

    tlc_step #(
        .MAX_DURATION(MAX_DURATION)
    ) u_step (
        .st_i   (st_reg),
        .item_i (in_item_reg),
        .st_o   (st_step),
        .res_o  (res_step)
    );

    // A held beat moves on whenever the result register is free or being emptied.
    assign process  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || process;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_item_next = in_item_reg;
        if (s_accept) begin
            in_item_next = '{
                sec_tick:   s_tdata[0],
                blink_tick: s_tdata[1],
                seg_tick:   s_tdata[2],
                btn_mode:   s_tdata[3],
                btn_up:     s_tdata[4],
                btn_down:   s_tdata[5],
                btn_commit: s_tdata[6]
            };
        end

        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (process) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        st_next       = process ? st_step : st_reg;
        out_data_next = out_data_reg;
        if (process) begin
            out_data_next = {2'b00, 2'(res_step.current_mode), res_step.display_right,
                             res_step.display_left, res_step.lamps};
        end

        if (process) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= RESET_STATE;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            st_reg        <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg  <= in_item_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/tlc_checker.sv */
// Port-level checks of the traffic light controller core, bound to the top level.
// Depends on tlc_pkg and traffic_light_controller_core.
`timescale 1ns / 1ps
`default_nettype none

module tlc_checker (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_tready,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [tlc_pkg::OUT_W-1:0] m_tdata
);

    logic [1:0] seen_mode_reg, seen_mode_next;
    logic [5:0] colour_mask;

    // The mode a scan runs in is the mode reported by the previous result beat.
    assign seen_mode_next = (m_tvalid && m_tready) ? m_tdata[21:20] : seen_mode_reg;
    assign colour_mask    = 6'b001001 << (seen_mode_reg - 2'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_mode_reg <= 2'(tlc_pkg::MODE_NORMAL);
        end else begin
            seen_mode_reg <= seen_mode_next;
        end
    end

    // Both registers are empty right after reset, so the input side is open.
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("s_tready low in the cycle after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // Each road lights at most one lamp at any time.
    a_one_lamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(m_tdata[2:0]) && $onehot0(m_tdata[5:3]))
        else $error("more than one lamp lit on a road");

    // A scan run in an adjust mode leaves only that mode's colour lit.
    a_adjust_colour: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (seen_mode_reg != tlc_pkg::MODE_NORMAL)
            |-> (m_tdata[5:0] & ~colour_mask) == 6'd0)
        else $error("wrong colour lit in an adjust mode");

    // Input beats waiting with a full pipeline only clear when the output drains.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input side blocked without an output stall");

endmodule

bind traffic_light_controller_core tlc_checker u_tlc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
